### hdl/shelf_first_fit_packer_unit_macros.svh
// assertion macros for the shelf first-fit packer
`ifndef SHELF_FIRST_FIT_PACKER_UNIT_MACROS_SVH
`define SHELF_FIRST_FIT_PACKER_UNIT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define SFFP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sffp same-cycle check failed");

// condition holds in the cycle after the trigger
`define SFFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sffp next-cycle check failed");

`endif

### hdl/sffp_pkg.sv
// shared types and constants of the shelf first-fit packer
package sffp_pkg;

  localparam int TAG_W    = 12;
  localparam int DIM_W    = 13;
  localparam int LEN_W    = 14;
  localparam int MARGIN_W = 4;
  localparam int LINE_W   = 5;
  localparam int Y_W      = 19;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MARGIN = 1'b1;

  localparam logic [LEN_W-1:0]    ATLAS_WIDTH_RST = 14'd1024;
  localparam logic [MARGIN_W-1:0] EDGE_MARGIN_RST = 4'd2;

  localparam logic RK_PLACE  = 1'b0;
  localparam logic RK_REPORT = 1'b1;

  typedef struct packed {
    logic [TAG_W-1:0] entry_tag;
    logic [DIM_W-1:0] entry_width;
    logic [DIM_W-1:0] entry_height;
    logic             last_entry;
  } entry_t;

  typedef struct packed {
    logic              result_kind;
    logic [TAG_W-1:0]  placed_tag;
    logic [DIM_W-1:0]  pos_x;
    logic [LINE_W-1:0] line_index;
    logic [Y_W-1:0]    line_y;
    logic [Y_W-1:0]    total_height;
    logic              no_room;
    logic              last_result;
  } result_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic [LEN_W-1:0] height;
  } shelf_t;

  localparam int SHELF_W = 2 * LEN_W;

endpackage

### hdl/sffp_in_if.sv
// rectangle input channel of the shelf first-fit packer
interface sffp_in_if;
  logic              valid;
  logic              ready;
  sffp_pkg::entry_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/sffp_out_if.sv
// result output channel of the shelf first-fit packer
interface sffp_out_if;
  logic               valid;
  logic               ready;
  sffp_pkg::result_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/shelf_first_fit_packer_unit.sv
// Shelf first-fit packer: places padded rectangles on the first shelf with room, one rectangle
// per input beat, and after the last rectangle reports every shelf's y start and the total
// height. Shelf lengths and heights live in one ram with a registered read, so the first-fit
// search reads the open shelves one after another and, if none has room, opens a new shelf or
// reports no room. A rectangle marked last adds a turn state, a summing pass and a report pass
// over the open shelves; the report pass waits whenever the output side stalls. One result
// beat waits in the output register while the block carries on. Configuration must be written
// only while the block is idle and applies from the next rectangle; the block itself does not
// enforce this.
`include "shelf_first_fit_packer_unit_macros.svh"

module shelf_first_fit_packer_unit #(
  parameter int MAX_SHELVES = 32,
  parameter int MAX_ATLAS   = 8192
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_en,
  input  logic [sffp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sffp_pkg::CFG_DATA_W-1:0]     cfg_data,
  sffp_in_if.sink                             rects,
  sffp_out_if.source                          results
);

  localparam int IDX_W  = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int USED_W = $clog2(MAX_SHELVES + 1);
  localparam int LEN_W  = sffp_pkg::LEN_W;
  localparam int DIM_W  = sffp_pkg::DIM_W;
  localparam int Y_W    = sffp_pkg::Y_W;
  localparam logic [USED_W-1:0] USED_MAX  = USED_W'(MAX_SHELVES);
  localparam logic [USED_W-1:0] USED_ONE  = USED_W'(1);
  localparam logic [LEN_W-1:0]  ATLAS_CAP = LEN_W'(MAX_ATLAS);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_PLACE  = 6'b000100,
    S_TURN   = 6'b001000,
    S_SUM    = 6'b010000,
    S_REPORT = 6'b100000
  } state_t;

  state_t state;

  logic [LEN_W-1:0]              atlas_width;
  logic [sffp_pkg::MARGIN_W-1:0] edge_margin;
  logic [USED_W-1:0]             used;
  logic                          shelf0_fresh;
  logic [IDX_W-1:0]              rd_idx;

  logic [sffp_pkg::TAG_W-1:0]    tag;
  logic                          last;
  logic [LEN_W-1:0]              pw;
  logic [LEN_W-1:0]              ph;

  logic [IDX_W-1:0]              place_idx;
  logic [LEN_W-1:0]              new_len;
  logic [LEN_W-1:0]              new_hgt;
  logic [DIM_W-1:0]              place_x;
  logic                          place_none;
  logic                          open_new;

  logic [Y_W-1:0]                total;
  logic [Y_W-1:0]                acc;

  logic                          out_valid;
  sffp_pkg::result_t             out_data;
  sffp_pkg::result_t             out_data_next;
  logic                          out_load;

  // ram signals
  logic                          ram_we;
  logic [IDX_W-1:0]              raddr;
  sffp_pkg::shelf_t              ram_rdata;
  sffp_pkg::shelf_t              ram_wdata;
  sffp_pkg::shelf_t              shelf_rd;

  logic [LEN_W-1:0]              limit;
  logic [LEN_W-1:0]              margin2;
  logic [LEN_W:0]                fit_sum;
  logic                          fits;
  logic                          rd_is_last;
  logic [LEN_W-1:0]              pos_sum;
  logic                          slot_free;
  logic                          accept;

  assign limit      = (atlas_width < ATLAS_CAP) ? atlas_width : ATLAS_CAP;
  assign margin2    = LEN_W'({edge_margin, 1'b0});
  // entry 0 has never been written since the shelves were cleared
  assign shelf_rd   = (rd_idx == '0 && shelf0_fresh) ? '0 : ram_rdata;
  assign fit_sum    = {1'b0, shelf_rd.length} + {1'b0, pw};
  assign fits       = fit_sum < {1'b0, limit};
  assign rd_is_last = (rd_idx == IDX_W'(used - USED_ONE));
  assign pos_sum    = shelf_rd.length + LEN_W'(edge_margin);
  assign slot_free  = !out_valid || results.ready;
  assign accept     = rects.valid && rects.ready;
  assign out_load   = slot_free && (state == S_PLACE || state == S_REPORT);

  assign rects.ready   = (state == S_IDLE);
  assign results.valid = out_valid;
  assign results.data  = out_data;

  assign ram_we           = (state == S_PLACE) && slot_free && !place_none;
  assign ram_wdata.length = new_len;
  assign ram_wdata.height = new_hgt;

  // beat loaded into the output register: a shelf report or a placement
  always_comb begin
    out_data_next = '0;
    if (state == S_REPORT) begin
      out_data_next.result_kind  = sffp_pkg::RK_REPORT;
      out_data_next.line_index   = sffp_pkg::LINE_W'(rd_idx);
      out_data_next.line_y       = acc + Y_W'(edge_margin);
      out_data_next.total_height = total;
      out_data_next.last_result  = rd_is_last;
    end else begin
      out_data_next.result_kind  = sffp_pkg::RK_PLACE;
      out_data_next.placed_tag   = tag;
      out_data_next.pos_x        = place_x;
      out_data_next.line_index   = sffp_pkg::LINE_W'(place_idx);
      out_data_next.no_room      = place_none;
      out_data_next.last_result  = !last;
    end
  end

  // read address: the entry whose data is wanted in the next cycle
  always_comb begin
    raddr = '0;
    unique case (state)
      S_SCAN: begin
        if (!fits && !rd_is_last) begin
          raddr = rd_idx + IDX_W'(1);
        end
      end
      S_SUM: begin
        if (!rd_is_last) begin
          raddr = rd_idx + IDX_W'(1);
        end
      end
      S_REPORT: begin
        if (!slot_free) begin
          raddr = rd_idx;
        end else if (!rd_is_last) begin
          raddr = rd_idx + IDX_W'(1);
        end
      end
      S_IDLE, S_PLACE, S_TURN: begin
        raddr = '0;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  sffp_ram #(
    .WIDTH (sffp_pkg::SHELF_W),
    .DEPTH (MAX_SHELVES)
  ) u_shelf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (place_idx),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    rd_idx <= raddr;

    if (rst) begin
      state        <= S_IDLE;
      atlas_width  <= sffp_pkg::ATLAS_WIDTH_RST;
      edge_margin  <= sffp_pkg::EDGE_MARGIN_RST;
      used         <= USED_ONE;
      shelf0_fresh <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_en) begin
        if (cfg_index == sffp_pkg::CFG_ATLAS_WIDTH) begin
          atlas_width <= cfg_data[LEN_W-1:0];
        end else begin
          edge_margin <= cfg_data[sffp_pkg::MARGIN_W-1:0];
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
        out_data  <= out_data_next;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            tag   <= rects.data.entry_tag;
            last  <= rects.data.last_entry;
            pw    <= LEN_W'(rects.data.entry_width) + margin2;
            ph    <= LEN_W'(rects.data.entry_height) + margin2;
            state <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (fits) begin
            place_idx  <= rd_idx;
            new_len    <= fit_sum[LEN_W-1:0];
            new_hgt    <= (ph > shelf_rd.height) ? ph : shelf_rd.height;
            place_x    <= pos_sum[DIM_W-1:0];
            place_none <= 1'b0;
            open_new   <= 1'b0;
            state      <= S_PLACE;
          end else if (rd_is_last) begin
            if (used < USED_MAX) begin
              place_idx  <= IDX_W'(used);
              new_len    <= pw;
              new_hgt    <= ph;
              place_x    <= DIM_W'(edge_margin);
              place_none <= 1'b0;
              open_new   <= 1'b1;
            end else begin
              place_idx  <= '0;
              place_x    <= '0;
              place_none <= 1'b1;
              open_new   <= 1'b0;
            end
            state <= S_PLACE;
          end
        end

        S_PLACE: begin
          if (slot_free) begin
            if (open_new) begin
              used <= used + USED_ONE;
            end
            if (!place_none && place_idx == '0) begin
              shelf0_fresh <= 1'b0;
            end
            state <= last ? S_TURN : S_IDLE;
          end
        end

        // a turn state so the summing pass reads entry 0 after the write-back
        S_TURN: begin
          total <= '0;
          state <= S_SUM;
        end

        S_SUM: begin
          total <= total + Y_W'(shelf_rd.height);
          if (rd_is_last) begin
            acc   <= '0;
            state <= S_REPORT;
          end
        end

        S_REPORT: begin
          if (slot_free) begin
            acc <= acc + Y_W'(shelf_rd.height);
            if (rd_is_last) begin
              used         <= USED_ONE;
              shelf0_fresh <= 1'b1;
              state        <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SFFP_ASSERT_NOW(a_used_range, clk, rst, 1'b1, (used != '0 && used <= USED_MAX))
  `SFFP_ASSERT_NOW(a_no_room_only_full, clk, rst,
    (results.valid && results.data.result_kind == sffp_pkg::RK_PLACE && results.data.no_room),
    (used == USED_MAX))
  `SFFP_ASSERT_NEXT(a_clear_after_report, clk, rst,
    (state == S_REPORT && slot_free && rd_is_last),
    (used == USED_ONE && shelf0_fresh && state == S_IDLE))

endmodule

### hdl/sffp_ram.sv
// generic single-port-write, single-port-read ram with registered read
module sffp_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
